### sv/zcrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcrs_pkg
// Shared types and constants of the zero-crossing relay switch.
// ----------------------------------------------------------------------------
package zcrs_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int TIME_BITS_DEF   = 32;

    localparam int DLY_BITS     = 16;
    localparam int STEP_BITS    = $clog2(DLY_BITS);
    localparam int LAG_BITS     = 16;
    localparam int LIMIT_BITS   = 8;
    localparam int THR_BITS     = 23;
    localparam int CFG_W        = 23;
    localparam int CFG_IDX_BITS = 2;
    localparam int STATUS_BITS  = 3;
    localparam int IN_USER_W    = 3;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [LAG_BITS-1:0]   LAG_MIN_RST = 16'd333;
    localparam logic [LAG_BITS-1:0]   LAG_MAX_RST = 16'd555;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RST   = 8'd42;
    localparam logic [THR_BITS-1:0]   THR_RST     = 23'd10;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_IDLE     = 3'd0,
        ST_WAIT     = 3'd1,
        ST_SWITCH   = 3'd2,
        ST_NOLOAD   = 3'd3,
        ST_SENSOR   = 3'd4,
        ST_LAG      = 3'd5,
        ST_MATH     = 3'd6,
        ST_WATCHDOG = 3'd7
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LAG_MIN = 2'd0,
        CFG_LAG_MAX = 2'd1,
        CFG_LIMIT   = 2'd2,
        CFG_THR     = 2'd3
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic dinit;
        logic dstep;
        logic check;
        logic commit;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_sts;

endpackage

### sv/zero_crossing_relay_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_relay_switch
// Relay switch timing from the zero crossing of sampled voltage or current.
// ----------------------------------------------------------------------------
// A beat on the slave stream is either a start (arms an on or off request)
// or a sample with its timestamp. Every input beat gives exactly one result
// beat on the master stream: a status, the relay and pump drive levels after
// the beat, and the interpolated delay to switch when the status is switch.
// The configuration port writes the lag window, the sample limit and the
// no-load threshold; write it only while no beat is in flight.
// Most beats are captured, evaluated and committed; a beat that finds a
// crossing inside the lag window also passes a multiply step, the 16-step
// serial divider that yields one delay bit per cycle, and a range check.
// One beat is worked at a time; the next is accepted in the cycle after the
// previous result is loaded into the output register.
// Reset clears the request state, restores the register defaults and
// empties the output. When the receiver stalls, the result waits in the
// output register; one further beat may be accepted and worked, and it
// waits for the register to drain before its result is loaded.
// ----------------------------------------------------------------------------
module zero_crossing_relay_switch
    import zcrs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave stream
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] i_s_tdata, // sample, time_us
    input  logic [IN_USER_W-1:0]    i_s_tuser,  // cmd, onoff, sample_error
    // master stream
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,  // relay_on, pump_on, switch_delay_us
    output logic [STATUS_BITS-1:0]  o_m_tuser,  // status
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_ctl                  ctl;
    t_sts                  sts;
    logic                  relay;
    logic                  pump;
    logic [DLY_BITS-1:0]   delay;

    zcrs_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    zcrs_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_s_tuser[0]),
        .i_onoff    (i_s_tuser[1]),
        .i_err      (i_s_tuser[2]),
        .i_sample   (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_time     (i_s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_status   (o_m_tuser),
        .o_relay    (relay),
        .o_pump     (pump),
        .o_delay    (delay)
    );

    assign o_m_tdata = OUT_TDATA_W'({delay, pump, relay});

endmodule

### sv/zcrs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcrs_dp
// Datapath: request state, crossing check, multiplier, serial divider and
// output register.
// ----------------------------------------------------------------------------
module zcrs_dp
    import zcrs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    output t_sts                    o_sts,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_cmd,
    input  logic                    i_onoff,
    input  logic                    i_err,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic [TIME_BITS-1:0]    i_time,
    input  logic                    i_m_tready,
    output logic                    o_valid,
    output logic [STATUS_BITS-1:0]  o_status,
    output logic                    o_relay,
    output logic                    o_pump,
    output logic [DLY_BITS-1:0]     o_delay
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + DLY_BITS;
    localparam int CMP_W  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    // configuration
    logic [LAG_BITS-1:0]   r_lag_min;
    logic [LAG_BITS-1:0]   r_lag_max;
    logic [LIMIT_BITS-1:0] r_limit;
    logic [THR_BITS-1:0]   r_thr;

    // request state
    logic                  r_busy;
    logic                  r_target;
    logic [LIMIT_BITS-1:0] r_count;
    logic [SB-1:0]         r_prev_smp;
    logic [TIME_BITS-1:0]  r_prev_tim;
    logic                  r_relay;
    logic                  r_pump;

    // captured beat
    logic                  r_cmd;
    logic                  r_onoff;
    logic                  r_err;
    logic [SB-1:0]         r_smp;
    logic [TIME_BITS-1:0]  r_tim;

    // work registers
    t_status               r_code;
    logic                  r_upd;
    logic [DLY_BITS-1:0]   r_gap16;
    logic [SB-1:0]         r_num;
    logic [SB-1:0]         r_den;
    logic [PROD_W-1:0]     r_prod;
    logic [SB:0]           r_rem;
    logic [DLY_BITS-1:0]   r_quo;

    // output register
    logic                  r_out_valid;
    logic [STATUS_BITS-1:0] r_status;
    logic                  r_relay_o;
    logic                  r_pump_o;
    logic [DLY_BITS-1:0]   r_delay;

    logic                  cur_neg, cur_zero, prev_neg, prev_zero;
    logic [SB-1:0]         cur_abs, prev_abs;
    logic [SB:0]           den_w, den_abs;
    logic [TIME_BITS-1:0]  gap;
    logic                  crossing, lag_bad, limit_hit, mag_big;
    logic [LIMIT_BITS-1:0] cnt_nxt;
    t_status               ev_code;
    logic                  ev_div;
    logic                  ev_upd;
    logic [SB:0]           trial;
    logic                  dv_bit;
    logic [SB:0]           dv_rem;
    logic                  n_relay, n_pump, n_busy;

    // ---------------- evaluation of the captured beat ----------------
    always_comb begin
        cur_neg   = r_smp[SB-1];
        cur_zero  = (r_smp == '0);
        prev_neg  = r_prev_smp[SB-1];
        prev_zero = (r_prev_smp == '0);
        cur_abs   = cur_neg ? (~r_smp + 1'b1) : r_smp;
        prev_abs  = prev_neg ? (~r_prev_smp + 1'b1) : r_prev_smp;
        den_w     = {r_smp[SB-1], r_smp} - {r_prev_smp[SB-1], r_prev_smp};
        den_abs   = den_w[SB] ? (~den_w + 1'b1) : den_w;
        gap       = r_tim - r_prev_tim;
        lag_bad   = (gap > TIME_BITS'(r_lag_max)) || (gap < TIME_BITS'(r_lag_min));
        crossing  = (r_count > LIMIT_BITS'(1))
                    && ((cur_neg != prev_neg) || (cur_zero != prev_zero));
        cnt_nxt   = r_count + 1'b1;
        limit_hit = (cnt_nxt >= r_limit);
        mag_big   = (CMP_W'(cur_abs) > CMP_W'(r_thr));

        ev_code = ST_WAIT;
        ev_div  = 1'b0;
        ev_upd  = 1'b0;
        if (!r_cmd) begin
            ev_code = ST_WAIT;
        end else if (!r_busy) begin
            ev_code = ST_IDLE;
        end else if (r_err) begin
            ev_code = ST_SENSOR;
        end else if (crossing) begin
            if (lag_bad) begin
                ev_code = ST_LAG;
            end else if (den_w == '0) begin
                ev_code = ST_MATH;
            end else begin
                ev_code = ST_SWITCH;
                ev_div  = 1'b1;
            end
        end else begin
            ev_upd = 1'b1;
            if (limit_hit) begin
                ev_code = (r_target || mag_big) ? ST_WATCHDOG : ST_NOLOAD;
            end else begin
                ev_code = ST_WAIT;
            end
        end
    end

    // one restoring step, remainder stays below the divisor
    always_comb begin
        trial  = {r_rem[SB-1:0], r_quo[DLY_BITS-1]};
        dv_bit = (trial >= {1'b0, r_den});
        dv_rem = dv_bit ? (trial - {1'b0, r_den}) : trial;
    end

    // levels after the item
    always_comb begin
        n_busy  = r_busy;
        n_pump  = r_pump;
        n_relay = r_relay;
        if (!r_cmd) begin
            n_busy = 1'b1;
            n_pump = r_onoff;
        end else begin
            case (r_code)
                ST_IDLE, ST_WAIT: begin
                end
                ST_SWITCH: begin
                    n_relay = r_target;
                    n_busy  = 1'b0;
                    n_pump  = 1'b0;
                end
                ST_NOLOAD: begin
                    n_relay = 1'b0;
                    n_busy  = 1'b0;
                    n_pump  = 1'b0;
                end
                default: begin
                    n_busy = 1'b0;
                    n_pump = 1'b0;
                end
            endcase
        end
    end

    assign o_sts.need_div = ev_div;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    // ---------------- configuration and request state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_min <= LAG_MIN_RST;
            r_lag_max <= LAG_MAX_RST;
            r_limit   <= LIMIT_RST;
            r_thr     <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LAG_MIN: r_lag_min <= i_cfg_data[LAG_BITS-1:0];
                CFG_LAG_MAX: r_lag_max <= i_cfg_data[LAG_BITS-1:0];
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_THR:     r_thr     <= i_cfg_data[THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_target    <= 1'b0;
            r_count     <= '0;
            r_prev_smp  <= '0;
            r_prev_tim  <= '0;
            r_relay     <= 1'b0;
            r_pump      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.commit) begin
                r_busy      <= n_busy;
                r_pump      <= n_pump;
                r_relay     <= n_relay;
                r_out_valid <= 1'b1;
                if (!r_cmd) begin
                    r_target <= r_onoff;
                    r_count  <= '0;
                end else if (r_upd) begin
                    r_prev_smp <= r_smp;
                    r_prev_tim <= r_tim;
                    r_count    <= cnt_nxt;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_onoff <= i_onoff;
            r_err   <= i_err;
            r_smp   <= i_sample;
            r_tim   <= i_time;
        end
        if (i_ctl.eval) begin
            r_code  <= ev_code;
            r_upd   <= ev_upd;
            r_gap16 <= gap[DLY_BITS-1:0];
            r_num   <= prev_abs;
            r_den   <= den_abs[SB-1:0];
        end
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(r_gap16);
        end
        // quotient is at most the gap, so only the low digits are divided out
        if (i_ctl.dinit) begin
            r_rem <= {1'b0, r_prod[PROD_W-1:DLY_BITS]};
            r_quo <= r_prod[DLY_BITS-1:0];
        end
        if (i_ctl.dstep) begin
            r_rem <= dv_rem;
            r_quo <= {r_quo[DLY_BITS-2:0], dv_bit};
        end
        if (i_ctl.check) begin
            r_code <= (r_quo > r_gap16) ? ST_MATH : ST_SWITCH;
        end
        if (i_ctl.commit) begin
            r_status  <= r_cmd ? r_code : ST_WAIT;
            r_relay_o <= n_relay;
            r_pump_o  <= n_pump;
            r_delay   <= (r_cmd && r_code == ST_SWITCH) ? r_quo : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_relay  = r_relay_o;
    assign o_pump   = r_pump_o;
    assign o_delay  = r_delay;

    // ---------------- checks ----------------
    a_pump_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pump |-> r_busy)
        else $error("pump driven with no request armed");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.dstep |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder not below divisor");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> (!r_out_valid || i_m_tready))
        else $error("result overwrites an untaken beat");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && r_cmd && r_code != ST_WAIT && r_code != ST_IDLE)
        |=> (!r_busy && !r_pump))
        else $error("finished request left armed");

endmodule

### sv/zcrs_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcrs_ctl
// Controller: sequences capture, evaluation, multiply, divide and commit.
// ----------------------------------------------------------------------------
module zcrs_ctl
    import zcrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_CHECK,
        S_COMMIT
    } t_state;

    t_state               r_state;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_ready <= 1'b1;
                    if (r_ready && i_s_tvalid) begin
                        r_state <= S_EVAL;
                        r_ready <= 1'b0;
                    end
                end
                S_EVAL: begin
                    r_state <= i_sts.need_div ? S_MUL : S_COMMIT;
                end
                S_MUL: begin
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_BITS'(DLY_BITS - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_ctl.capture = (r_state == S_IDLE) && r_ready && i_s_tvalid;
        o_ctl.eval    = (r_state == S_EVAL);
        o_ctl.mul     = (r_state == S_MUL);
        o_ctl.dinit   = (r_state == S_DINIT);
        o_ctl.dstep   = (r_state == S_DIV);
        o_ctl.check   = (r_state == S_CHECK);
        o_ctl.commit  = (r_state == S_COMMIT) && i_sts.out_free;
    end

    assign o_s_tready = r_ready;

endmodule

### tb/zcrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcrs_checker
// Watches the streams and the register port of the relay switch and predicts
// every result beat.
// ----------------------------------------------------------------------------
// Keeps its own copy of the request state and of the registers, works out
// the status, drive levels and switch delay for each accepted input beat,
// and compares each accepted result beat, field by field, with the oldest
// prediction. Mismatches and checked results are counted for the top.
// ----------------------------------------------------------------------------
module zcrs_checker
    import zcrs_pkg::*;
#(
    parameter int IN_TDATA_W = ((SAMPLE_BITS_DEF + TIME_BITS_DEF + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,  // sample, time_us
    input  logic [IN_USER_W-1:0]    i_s_tuser,  // cmd, onoff, sample_error
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_TDATA_W-1:0]  i_m_tdata,  // relay_on, pump_on, switch_delay_us
    input  logic [STATUS_BITS-1:0]  i_m_tuser,  // status
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_mismatches,
    output int                      o_results
);

    typedef struct {
        t_status              status;
        logic                 relay;
        logic                 pump;
        logic [DLY_BITS-1:0]  delay;
    } switch_result_t;

    switch_result_t switch_results_due[$];

    // register copies
    logic [LAG_BITS-1:0]   lag_min;
    logic [LAG_BITS-1:0]   lag_max;
    logic [LIMIT_BITS-1:0] limit;
    logic [THR_BITS-1:0]   no_load_thr;

    // request state
    logic                       busy;
    logic                       target_on;
    logic [7:0]                 sample_count;
    logic [SAMPLE_BITS_DEF-1:0] prev_sample;
    logic [TIME_BITS_DEF-1:0]   prev_time;
    logic                       relay_lvl;
    logic                       pump_lvl;

    int mismatch_count = 0;
    int result_count   = 0;

    function automatic int sign_of(input longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic switch_result_t predict_switch(
        input logic                       cmd,
        input logic                       onoff,
        input logic [SAMPLE_BITS_DEF-1:0] raw,
        input logic [TIME_BITS_DEF-1:0]   now,
        input logic                       err
    );
        switch_result_t           r;
        longint                   cur;
        longint                   prv;
        longint                   den;
        longint                   dly;
        longint                   mag;
        logic [TIME_BITS_DEF-1:0] gap;
        r.delay  = '0;
        r.status = ST_WAIT;
        if (!cmd) begin
            // a start drops any running request
            busy         = 1'b1;
            target_on    = onoff;
            sample_count = '0;
            pump_lvl     = onoff;
        end else if (!busy) begin
            r.status = ST_IDLE;
        end else if (err) begin
            r.status = ST_SENSOR;
        end else begin
            cur = longint'($signed(raw));
            prv = longint'($signed(prev_sample));
            if (sample_count > 8'd1 && sign_of(cur) != sign_of(prv)) begin
                gap = now - prev_time;
                den = cur - prv;
                if (gap > TIME_BITS_DEF'(lag_max) || gap < TIME_BITS_DEF'(lag_min)) begin
                    r.status = ST_LAG;
                end else if (den == 0) begin
                    r.status = ST_MATH;
                end else begin
                    dly = (-prv) * longint'(gap) / den;
                    if (dly < 0 || dly > longint'(gap)) begin
                        r.status = ST_MATH;
                    end else begin
                        relay_lvl = target_on;
                        r.status  = ST_SWITCH;
                        r.delay   = dly[DLY_BITS-1:0];
                    end
                end
            end else begin
                prev_sample  = raw;
                prev_time    = now;
                sample_count = sample_count + 8'd1;
                if (sample_count >= limit) begin
                    mag = (cur < 0) ? -cur : cur;
                    if (target_on || mag > longint'(no_load_thr)) begin
                        r.status = ST_WATCHDOG;
                    end else begin
                        relay_lvl = 1'b0;
                        r.status  = ST_NOLOAD;
                    end
                end
            end
        end
        // every outcome but waiting ends the request
        if (r.status != ST_WAIT && r.status != ST_IDLE) begin
            busy     = 1'b0;
            pump_lvl = 1'b0;
        end
        r.relay = relay_lvl;
        r.pump  = pump_lvl;
        return r;
    endfunction

    always @(posedge i_clk) begin
        switch_result_t want;
        logic           ok;
        if (!i_rst_n) begin
            lag_min      = LAG_MIN_RST;
            lag_max      = LAG_MAX_RST;
            limit        = LIMIT_RST;
            no_load_thr  = THR_RST;
            busy         = 1'b0;
            target_on    = 1'b0;
            sample_count = '0;
            prev_sample  = '0;
            prev_time    = '0;
            relay_lvl    = 1'b0;
            pump_lvl     = 1'b0;
            switch_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAG_MIN: lag_min     = i_cfg_data[LAG_BITS-1:0];
                    CFG_LAG_MAX: lag_max     = i_cfg_data[LAG_BITS-1:0];
                    CFG_LIMIT:   limit       = i_cfg_data[LIMIT_BITS-1:0];
                    CFG_THR:     no_load_thr = i_cfg_data[THR_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                switch_results_due.push_back(predict_switch(
                    i_s_tuser[0], i_s_tuser[1],
                    i_s_tdata[SAMPLE_BITS_DEF-1:0],
                    i_s_tdata[SAMPLE_BITS_DEF +: TIME_BITS_DEF],
                    i_s_tuser[2]));
            end
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (switch_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: status %0d tdata %h",
                                 i_m_tuser, i_m_tdata);
                end else begin
                    want = switch_results_due.pop_front();
                    ok = (i_m_tuser == want.status) && (i_m_tdata[0] == want.relay)
                        && (i_m_tdata[1] == want.pump)
                        && (i_m_tdata[2 +: DLY_BITS] == want.delay)
                        && (i_m_tdata[OUT_TDATA_W-1:DLY_BITS+2] == '0);
                    if (!ok) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d mismatch: expected status %0d relay %0b ",
                                      "pump %0b delay %0d, got status %0d relay %0b ",
                                      "pump %0b delay %0d pad %h"},
                                     result_count, want.status, want.relay, want.pump,
                                     want.delay, i_m_tuser, i_m_tdata[0], i_m_tdata[1],
                                     i_m_tdata[2 +: DLY_BITS],
                                     i_m_tdata[OUT_TDATA_W-1:DLY_BITS+2]);
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_results    <= result_count;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the zero-crossing relay switch.
// ----------------------------------------------------------------------------
// Drives a short directed set of requests, then random on and off requests
// with shaped waveforms and timestamps, across several register settings
// and idle/stall phases. Checking is done by zcrs_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import zcrs_pkg::*;

    localparam int IN_TDATA_W = ((SAMPLE_BITS_DEF + TIME_BITS_DEF + 7) / 8) * 8;

    logic                    clk;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [IN_USER_W-1:0]    s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_BITS-1:0]  m_tuser;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx  = CFG_LAG_MIN;
    logic [CFG_W-1:0]        cfg_data = '0;

    int mismatches;
    int results;
    int n_sent    = 0;
    int idle_pct  = 0;
    int stall_pct = 0;

    // register values as last written, used to shape the stimulus
    int lag_min_cfg = int'(LAG_MIN_RST);
    int lag_max_cfg = int'(LAG_MAX_RST);
    int limit_cfg   = int'(LIMIT_RST);
    int thr_cfg     = int'(THR_RST);

    zero_crossing_relay_switch dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    zcrs_checker #(.IN_TDATA_W(IN_TDATA_W)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_results    (results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_beat(input logic cmd, input logic onoff,
                             input logic [SAMPLE_BITS_DEF-1:0] smp,
                             input logic [TIME_BITS_DEF-1:0] ts, input logic err);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, smp};
        s_tuser  <= {err, onoff, cmd};
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // drain every outstanding beat, then give the block time to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results < n_sent) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_settings(input int lmin, input int lmax, input int lim,
                                 input int thr);
        lag_min_cfg = lmin;
        lag_max_cfg = lmax;
        limit_cfg   = lim;
        thr_cfg     = thr;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LAG_MIN;
        cfg_data <= CFG_W'(lmin);
        @(posedge clk);
        cfg_idx  <= CFG_LAG_MAX;
        cfg_data <= CFG_W'(lmax);
        @(posedge clk);
        cfg_idx  <= CFG_LIMIT;
        cfg_data <= CFG_W'(lim);
        @(posedge clk);
        cfg_idx  <= CFG_THR;
        cfg_data <= CFG_W'(thr);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] shape_sample(input int dir);
        int mag;
        int pick;
        pick = $urandom_range(9);
        if (dir == 0)
            return '0;
        case (pick)
            0: mag = (dir > 0) ? 8388607 : 8388608;
            1: begin
                // straddle the no-load threshold
                mag = thr_cfg - 1 + int'($urandom_range(2));
                if (mag < 1)
                    mag = 1;
                if (mag > 8388607)
                    mag = 8388607;
            end
            2, 3: mag = $urandom_range(16, 1);
            4, 5, 6: mag = $urandom_range(65535, 1);
            default: mag = $urandom_range(8388607, 1);
        endcase
        return (dir > 0) ? SAMPLE_BITS_DEF'(mag) : SAMPLE_BITS_DEF'(-mag);
    endfunction

    function automatic logic [TIME_BITS_DEF-1:0] pick_gap();
        case ($urandom_range(19))
            0: return -TIME_BITS_DEF'($urandom_range(1000, 1));
            1: return TIME_BITS_DEF'(lag_min_cfg - 1);
            2: return TIME_BITS_DEF'(lag_max_cfg + 1);
            3: return TIME_BITS_DEF'(lag_min_cfg);
            4: return TIME_BITS_DEF'(lag_max_cfg);
            5: return $urandom;
            default: return TIME_BITS_DEF'($urandom_range(lag_max_cfg, lag_min_cfg));
        endcase
    endfunction

    // one start beat, then a waveform that keeps its sign and flips it at most once
    task automatic run_request();
        logic                     onoff;
        int                       cross_at;
        int                       len;
        int                       dir;
        logic [TIME_BITS_DEF-1:0] ts;
        onoff = $urandom_range(1);
        send_beat(1'b0, onoff, $urandom, $urandom, $urandom_range(1));
        ts = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000) : $urandom;
        cross_at = ($urandom_range(9) == 0) ? -1 : $urandom_range(6, 1);
        len = (cross_at < 0) ? limit_cfg + 1 : cross_at + 1 + $urandom_range(1);
        if (len > limit_cfg + 2)
            len = limit_cfg + 2;
        dir = ($urandom_range(19) == 0) ? 0 : ($urandom_range(1) ? 1 : -1);
        for (int i = 0; i < len; i++) begin
            if (i == cross_at) begin
                if (dir == 0)
                    dir = $urandom_range(1) ? 1 : -1;
                else
                    dir = ($urandom_range(9) == 0) ? 0 : -dir;
            end
            if (i > 0)
                ts = ts + pick_gap();
            send_beat(1'b1, $urandom_range(1), shape_sample(dir), ts,
                      ($urandom_range(29) == 0));
        end
    endtask

    task automatic run_random(input int budget);
        int first;
        first = n_sent;
        while (n_sent - first < budget) begin
            if ($urandom_range(99) < 6)
                send_beat($urandom_range(1), $urandom_range(1), $urandom, $urandom,
                          $urandom_range(1));
            else
                run_request();
        end
    endtask

    task automatic run_phase(input int mode, input int lmin, input int lmax,
                             input int lim, input int thr, input int budget);
        wait_idle();
        load_settings(lmin, lmax, lim, thr);
        case (mode)
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            3: begin idle_pct = 30; stall_pct = 30; end
            default: begin idle_pct = 0; stall_pct = 0; end
        endcase
        run_random(budget);
    endtask

    // defaults: lag window 333..555, limit 42, threshold 10
    task automatic run_directed();
        // samples with no request are ignored
        send_beat(1'b1, 1'b1, 24'h7F_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(1'b1, 1'b0, 24'h80_0000, 32'h0000_0000, 1'b0);
        // switch on, the timestamp wrapping through zero
        send_beat(1'b0, 1'b1, 24'h80_0000, 32'hFFFF_FFFF, 1'b1);
        send_beat(1'b1, 1'b0, 24'h7F_FFFF, 32'hFFFF_FE00, 1'b0);
        send_beat(1'b1, 1'b1, 24'd100,     32'hFFFF_FF90, 1'b0);
        send_beat(1'b1, 1'b0, 24'h80_0000, 32'h0000_01BB, 1'b0);
        // switch off on a step to zero, delay equal to the gap
        send_beat(1'b0, 1'b0, 24'h00_0000, 32'h0000_0000, 1'b0);
        send_beat(1'b1, 1'b0, 24'd5,       32'd1000,      1'b0);
        send_beat(1'b1, 1'b0, 24'd5,       32'd1333,      1'b0);
        send_beat(1'b1, 1'b0, 24'd0,       32'd1666,      1'b0);
        // interpolated delay inside the gap
        send_beat(1'b0, 1'b1, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd1000,    32'd5000,      1'b0);
        send_beat(1'b1, 1'b0, 24'd1000,    32'd5400,      1'b0);
        send_beat(1'b1, 1'b0, -24'sd3000,  32'd5800,      1'b0);
        // gap just below the window
        send_beat(1'b0, 1'b1, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd10,      32'd100,       1'b0);
        send_beat(1'b1, 1'b0, 24'd10,      32'd500,       1'b0);
        send_beat(1'b1, 1'b0, -24'sd10,    32'd832,       1'b0);
        // restart while busy, then gap just above the window
        send_beat(1'b0, 1'b1, 24'd0,       32'd0,         1'b0);
        send_beat(1'b0, 1'b0, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd10,      32'd100,       1'b0);
        send_beat(1'b1, 1'b0, -24'sd10,    32'd433,       1'b0);
        send_beat(1'b1, 1'b0, -24'sd10,    32'd866,       1'b0);
        send_beat(1'b1, 1'b0, 24'd10,      32'd1422,      1'b0);
        // sensor error
        send_beat(1'b0, 1'b1, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd7,       32'd10,        1'b1);
        // timestamp going back
        send_beat(1'b0, 1'b1, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd1,       32'd1000,      1'b0);
        send_beat(1'b1, 1'b0, 24'd2,       32'd1400,      1'b0);
        send_beat(1'b1, 1'b0, -24'sd2,     32'd900,       1'b0);
        // crossing out of zero
        send_beat(1'b0, 1'b0, 24'd0,       32'd0,         1'b0);
        send_beat(1'b1, 1'b0, 24'd0,       32'd2000,      1'b0);
        send_beat(1'b1, 1'b0, 24'd0,       32'd2400,      1'b0);
        send_beat(1'b1, 1'b0, 24'd7,       32'd2800,      1'b0);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(80);
        run_phase(1, 0, 65535, 3, 0, 85);
        run_phase(2, 400, 500, 255, 8388607, 85);
        run_phase(3, 333, 555, 8, 100, 85);
        // limits below three end the request early
        run_phase(0, 65535, 65535, 1, 10, 85);
        run_phase(1, 0, 0, 0, 5, 85);
        run_phase(2, 100, 1000, 2, 1000, 85);
        run_phase(3, $urandom_range(400), $urandom_range(900, 300), $urandom_range(40, 3),
                  $urandom_range(8388607), 85);
        run_phase(0, $urandom_range(65535), $urandom_range(65535), $urandom_range(20, 3),
                  $urandom_range(50), 85);
        s_tvalid <= 1'b0;
        while (results < n_sent) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && results == n_sent) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
